/* rtl/xtea_pkg.sv */
package xtea_pkg;

  localparam int unsigned XTEA_ROUNDS = 32;
  localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;
  localparam int unsigned KEY_SHIFT = 11;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ZERO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_THREE = 2'd3;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QDEPTH = 2;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_ENC,
    OP_DEC
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } st_t;

  function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

/* rtl/xtea_front.sv */
module xtea_front
  import xtea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic              in_mode,
  input  logic [WORD_W-1:0] in_block_first,
  input  logic [WORD_W-1:0] in_block_second,
  output q_t                q_head,
  input  logic              q_pop
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  item_t            slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  item_t            new_item;

  assign in_stall = (cnt_r == CNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;

  // Decode the item into the operation the back end will run.
  always_comb begin
    if (!in_command) begin
      new_item.op = OP_READ;
    end else if (in_mode) begin
      new_item.op = OP_DEC;
    end else begin
      new_item.op = OP_ENC;
    end
    new_item.first  = in_block_first;
    new_item.second = in_block_second;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = slot_r[rd_ptr_r];

endmodule

/* rtl/xtea_back.sv */
module xtea_back
  import xtea_pkg::*;
#(
  parameter int unsigned ROUNDS = XTEA_ROUNDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  key_t              key,
  input  q_t                q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_result_first,
  output logic [WORD_W-1:0] out_result_second
);

  localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [WORD_W-1:0] DEC_SUM = WORD_W'(64'(XTEA_DELTA) * 64'(ROUNDS));

  st_t               st_r, st_nxt;
  logic [RND_W-1:0]  cnt_r;
  logic [WORD_W-1:0] v0_r, v1_r, s_r;
  logic              dec_r;
  logic [WORD_W-1:0] last_first_r, last_second_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_first_r, out_second_r;

  logic              out_free, is_read, last_rnd;
  logic              start, step, fin, fin_emit, rd_emit, hold_emit;

  logic [WORD_W-1:0] s_up, s_dn, enc_v0, enc_v1, dec_v0, dec_v1;
  logic [WORD_W-1:0] rnd_v0, rnd_v1, rnd_s;

  assign out_free = !out_valid_r || !out_stall;
  assign is_read  = (q_head.item.op == OP_READ);
  assign last_rnd = (cnt_r == RND_W'(ROUNDS - 1));

  // One full round per cycle; the direction picks which half goes first.
  always_comb begin
    s_up   = s_r + XTEA_DELTA;
    s_dn   = s_r - XTEA_DELTA;
    enc_v0 = v0_r + (xtea_mix(v1_r) ^ (s_r + key[s_r[1:0]]));
    enc_v1 = v1_r + (xtea_mix(enc_v0) ^ (s_up + key[s_up[KEY_SHIFT+1:KEY_SHIFT]]));
    dec_v1 = v1_r - (xtea_mix(v0_r) ^ (s_r + key[s_r[KEY_SHIFT+1:KEY_SHIFT]]));
    dec_v0 = v0_r - (xtea_mix(dec_v1) ^ (s_dn + key[s_dn[1:0]]));
    rnd_v0 = dec_r ? dec_v0 : enc_v0;
    rnd_v1 = dec_r ? dec_v1 : enc_v1;
    rnd_s  = dec_r ? s_dn : s_up;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_head.valid && !is_read) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_rnd) begin
          st_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start     = 1'b0;
    rd_emit   = 1'b0;
    step      = 1'b0;
    fin       = 1'b0;
    fin_emit  = 1'b0;
    hold_emit = 1'b0;
    case (st_r)
      ST_IDLE: begin
        start   = q_head.valid && !is_read;
        rd_emit = q_head.valid && is_read && out_free;
      end
      ST_RUN: begin
        step     = 1'b1;
        fin      = last_rnd;
        fin_emit = last_rnd && out_free;
      end
      ST_HOLD: begin
        hold_emit = out_free;
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  assign q_pop         = start || rd_emit;
  assign out_valid_nxt = fin_emit || rd_emit || hold_emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      last_first_r  <= '0;
      last_second_r <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (fin) begin
        last_first_r  <= rnd_v0;
        last_second_r <= rnd_v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v0_r  <= q_head.item.first;
      v1_r  <= q_head.item.second;
      dec_r <= (q_head.item.op == OP_DEC);
      s_r   <= (q_head.item.op == OP_DEC) ? DEC_SUM : '0;
    end else if (step) begin
      v0_r <= rnd_v0;
      v1_r <= rnd_v1;
      s_r  <= rnd_s;
    end
    if (fin_emit) begin
      out_first_r  <= rnd_v0;
      out_second_r <= rnd_v1;
    end else if (rd_emit || hold_emit) begin
      out_first_r  <= last_first_r;
      out_second_r <= last_second_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_first  = out_first_r;
  assign out_result_second = out_second_r;

endmodule

/* rtl/xtea_cipher_engine_core.sv */
// XTEA block cipher, 64-bit block as two 32-bit words, 128-bit key in four
// configuration words. Items enter a two-entry queue, so a new item is taken
// while the cipher works and while a result waits on the output register.
// A read item (command 0) runs no rounds in the back end; a cipher item is first
// loaded, then run one full round per cycle in the single round unit.
// Every item returns exactly one result.
// Key words are used as they stand, so write them only while the block is idle.
module xtea_cipher_engine_core
  import xtea_pkg::*;
#(
  parameter int unsigned ROUNDS = XTEA_ROUNDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic                 in_mode,
  input  logic [WORD_W-1:0]    in_block_first,
  input  logic [WORD_W-1:0]    in_block_second,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_result_first,
  output logic [WORD_W-1:0]    out_result_second,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  key_t key_r;
  q_t   q_head;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_ZERO:  key_r[0] <= cfg_wdata;
        REG_KEY_ONE:   key_r[1] <= cfg_wdata;
        REG_KEY_TWO:   key_r[2] <= cfg_wdata;
        REG_KEY_THREE: key_r[3] <= cfg_wdata;
        default:       key_r    <= key_r;
      endcase
    end
  end

  xtea_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_mode         (in_mode),
    .in_block_first  (in_block_first),
    .in_block_second (in_block_second),
    .q_head          (q_head),
    .q_pop           (q_pop)
  );

  xtea_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .key               (key_r),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_first  (out_result_first),
    .out_result_second (out_result_second)
  );

  // The back end never takes an item from an empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("item popped from an empty queue");

  // The front only pushes back when it holds items.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_head.valid)
    else $error("input stalled while the queue is empty");

  // No result is offered right after reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

/* sim/xtea_cipher_engine_core_test.sv */
module xtea_cipher_engine_core_test;
  import xtea_pkg::*;

  localparam logic CMD_READ    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;
  localparam logic MODE_ENC    = 1'b0;
  localparam logic MODE_DEC    = 1'b1;

  localparam int IDLE_PCT      = 22;
  localparam int DIRECTED_ROWS = 14;

  typedef struct packed {
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } word_pair_t;

  typedef struct packed {
    logic              command;
    logic              mode;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
    logic              fixed;
    logic [WORD_W-1:0] want_first;
    logic [WORD_W-1:0] want_second;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_command = CMD_READ;
  logic                 in_mode = MODE_ENC;
  logic [WORD_W-1:0]    in_block_first = '0;
  logic [WORD_W-1:0]    in_block_second = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_result_first;
  logic [WORD_W-1:0]    out_result_second;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_ZERO;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // Predictor state: key words, last stored block, direction of the last cipher item.
  logic [WORD_W-1:0] key_words [KEY_WORDS] = '{default: '0};
  word_pair_t        stored_pair = '0;
  logic              last_mode = MODE_DEC;

  word_pair_t pending_blocks [$];
  int         fail_count = 0;
  int         idle_pct = IDLE_PCT;

  // Rows with fixed set carry their expected result; the rest use the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,    MODE_ENC, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0},
    '{CMD_READ,    MODE_DEC, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_ENC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_READ,    MODE_DEC, 32'h1234_5678, 32'h9abc_def0, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_DEC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_ENC, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_DEC, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_ENC, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_DEC, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_ENC, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_DEC, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_ENC, 32'h1234_5678, 32'h9abc_def0, 1'b0, 32'h0, 32'h0},
    '{CMD_READ,    MODE_ENC, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'h0, 32'h0},
    '{CMD_PROCESS, MODE_DEC, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'h0, 32'h0}
  };

  xtea_cipher_engine_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_mode           (in_mode),
    .in_block_first    (in_block_first),
    .in_block_second   (in_block_second),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_first  (out_result_first),
    .out_result_second (out_result_second),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic word_pair_t encipher_pair(input word_pair_t plain);
    logic [WORD_W-1:0] v0, v1, sum;
    v0 = plain.first;
    v1 = plain.second;
    sum = '0;
    for (int r = 0; r < XTEA_ROUNDS; r++) begin
      v0 += ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_words[sum[1:0]]));
      sum += XTEA_DELTA;
      v1 += ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_words[sum[KEY_SHIFT +: 2]]));
    end
    return '{first: v0, second: v1};
  endfunction

  function automatic word_pair_t decipher_pair(input word_pair_t coded);
    logic [WORD_W-1:0] v0, v1, sum;
    v0 = coded.first;
    v1 = coded.second;
    // The running sum wraps, so the start value is delta times the round count mod 2^32.
    sum = XTEA_DELTA * XTEA_ROUNDS;
    for (int r = 0; r < XTEA_ROUNDS; r++) begin
      v1 -= ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_words[sum[KEY_SHIFT +: 2]]));
      sum -= XTEA_DELTA;
      v0 -= ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_words[sum[1:0]]));
    end
    return '{first: v0, second: v1};
  endfunction

  function automatic word_pair_t predict_block(input logic command, input logic mode,
                                               input word_pair_t block);
    if (command == CMD_PROCESS) begin
      stored_pair = (mode == MODE_ENC) ? encipher_pair(block) : decipher_pair(block);
      last_mode = mode;
    end
    return stored_pair;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Offers one item, then returns at the edge that accepts it.
  task automatic send_item(input logic command, input logic mode,
                           input logic [WORD_W-1:0] first, input logic [WORD_W-1:0] second,
                           input logic fixed, input word_pair_t given);
    word_pair_t predicted;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= command;
    in_mode         <= mode;
    in_block_first  <= first;
    in_block_second <= second;
    do @(posedge clk); while (in_stall);
    predicted = predict_block(command, mode, '{first: first, second: second});
    pending_blocks.push_back(fixed ? given : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_blocks.size() != 0);
  endtask

  // The write enable stays high across the four writes.
  task automatic load_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_KEY_ZERO;
    cfg_wdata <= k0;
    @(posedge clk);
    key_words[REG_KEY_ZERO] = k0;
    cfg_index <= REG_KEY_ONE;
    cfg_wdata <= k1;
    @(posedge clk);
    key_words[REG_KEY_ONE] = k1;
    cfg_index <= REG_KEY_TWO;
    cfg_wdata <= k2;
    @(posedge clk);
    key_words[REG_KEY_TWO] = k2;
    cfg_index <= REG_KEY_THREE;
    cfg_wdata <= k3;
    @(posedge clk);
    key_words[REG_KEY_THREE] = k3;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly cipher items, with inverse passes over the last stored block so that
  // encipher and decipher are seen undoing each other; reads fill the rest.
  task automatic send_random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_drained();
      end
      pick = $urandom_range(9);
      if (pick < 4) begin
        send_item(CMD_PROCESS, MODE_ENC, pick_word(), pick_word(), 1'b0, '0);
      end else if (pick < 6) begin
        send_item(CMD_PROCESS, MODE_DEC, pick_word(), pick_word(), 1'b0, '0);
      end else if (pick < 8) begin
        send_item(CMD_PROCESS, ~last_mode, stored_pair.first, stored_pair.second, 1'b0, '0);
      end else begin
        send_item(CMD_READ, 1'($urandom), pick_word(), pick_word(), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        $error("result with no item pending: first %08h, second %08h",
               out_result_first, out_result_second);
        fail_count++;
      end else begin
        if (out_result_first !== pending_blocks[0].first) begin
          $error("result_first: expected %08h, actual %08h",
                 pending_blocks[0].first, out_result_first);
          fail_count++;
        end
        if (out_result_second !== pending_blocks[0].second) begin
          $error("result_second: expected %08h, actual %08h",
                 pending_blocks[0].second, out_result_second);
          fail_count++;
        end
        void'(pending_blocks.pop_front());
      end
    end
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  initial begin
    #5_000_000;
    $display("xtea_cipher_engine_core verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keys are still at their reset value of zero here.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].command, directed_rows[i].mode,
                directed_rows[i].first, directed_rows[i].second, directed_rows[i].fixed,
                '{first: directed_rows[i].want_first, second: directed_rows[i].want_second});
    end
    send_random_items(150);

    wait_drained();
    load_keys('1, '1, '1, '1);
    send_random_items(200);

    // A long stretch with neither side idling.
    wait_drained();
    load_keys($urandom, $urandom, $urandom, $urandom);
    idle_pct = 0;
    send_random_items(200);
    idle_pct = IDLE_PCT;

    wait_drained();
    load_keys(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    send_random_items(200);

    wait_drained();
    load_keys($urandom, $urandom, $urandom, $urandom);
    send_random_items(200);

    wait_drained();
    load_keys('0, '0, '0, '0);
    send_random_items(60);

    wait_drained();
    repeat (2 * XTEA_ROUNDS) @(posedge clk);
    if (fail_count == 0) begin
      $display("xtea_cipher_engine_core verification clean");
    end else begin
      $display("xtea_cipher_engine_core verification failed");
    end
    $finish;
  end

endmodule
